>>> sv/svfeq_pkg.sv
package svfeq_pkg;

  localparam int BANDS_DEF    = 24;
  localparam int CHANNELS_DEF = 8;
  localparam int ACC_W        = 48;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_WRITE  = 1'b1;

  localparam logic [2:0] SEL_A1     = 3'd0;
  localparam logic [2:0] SEL_A2     = 3'd1;
  localparam logic [2:0] SEL_A3     = 3'd2;
  localparam logic [2:0] SEL_M0     = 3'd3;
  localparam logic [2:0] SEL_M1     = 3'd4;
  localparam logic [2:0] SEL_M2     = 3'd5;
  localparam logic [2:0] SEL_BYPASS = 3'd6;

  typedef struct packed {
    logic               operation;
    logic [2:0]         channel;
    logic signed [23:0] sample_in;
    logic [4:0]         band;
    logic [2:0]         coef_select;
    logic signed [31:0] coef_value;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0] sample_out;
    logic [2:0]         out_channel;
  } out_item_t;

  // Coefficient write broadcast to every band cell.
  typedef struct packed {
    logic               en;
    logic [4:0]         band;
    logic [2:0]         sel;
    logic signed [31:0] value;
  } coef_wr_t;

  // Running sample handed from one band cell to the next.
  typedef struct packed {
    logic               vld;
    logic signed [31:0] x;
  } link_t;

  typedef enum logic [1:0] {
    C_IDLE,
    C_V3,
    C_RUN
  } cell_state_t;

  // Product rounded half up back to Q9.23 (ties go toward plus infinity for either sign).
  function automatic logic signed [ACC_W-1:0] rnd23(input logic signed [63:0] p);
    logic signed [63:0] q;
    q = (p + 64'sd4194304) >>> 23;
    return q[ACC_W-1:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [31:0] r;
    if (v > 48'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -48'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

>>> sv/svfeq_cell.sv
module svfeq_cell #(
  parameter int BAND_IDX = 0,
  parameter int CHANNELS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  svfeq_pkg::coef_wr_t wr,
  input  logic [2:0]          channel,
  input  svfeq_pkg::link_t    link_in,
  output svfeq_pkg::link_t    link_out
);
  import svfeq_pkg::*;

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic signed [31:0] coef_r [6];
  logic               bypass_r;
  logic signed [31:0] s1_mem_r [CHANNELS];
  logic signed [31:0] s2_mem_r [CHANNELS];

  cell_state_t        state_r, state_nxt;
  logic [2:0]         step_r;
  logic [CH_W-1:0]    ch_r;
  logic signed [31:0] x_r, s1_r, s2_r, v3_r, v1_r, v2_r;
  logic signed [63:0] prod_r;
  logic signed [ACC_W-1:0] acc_r;
  link_t              out_r;

  logic signed [31:0] op_a, op_b;
  logic signed [ACC_W-1:0] acc_sum;
  logic signed [33:0] s1_new, s2_new;
  logic               hit;

  assign hit = wr.en && (32'(wr.band) == BAND_IDX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) begin
        coef_r[i] <= '0;
      end
      bypass_r <= 1'b1;
    end else if (hit) begin
      case (wr.sel)
        SEL_A1:     coef_r[0] <= wr.value;
        SEL_A2:     coef_r[1] <= wr.value;
        SEL_A3:     coef_r[2] <= wr.value;
        SEL_M0:     coef_r[3] <= wr.value;
        SEL_M1:     coef_r[4] <= wr.value;
        SEL_M2:     coef_r[5] <= wr.value;
        SEL_BYPASS: bypass_r  <= wr.value[0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      C_IDLE: if (link_in.vld && !bypass_r) state_nxt = C_V3;
      C_V3:   state_nxt = C_RUN;
      C_RUN:  if (step_r == 3'd7) state_nxt = C_IDLE;
      default: state_nxt = C_IDLE;
    endcase
  end

  // One multiplier: the seven products of a band are issued one per cycle.
  always_comb begin
    case (step_r)
      3'd0:    begin op_a = coef_r[0]; op_b = s1_r; end
      3'd1:    begin op_a = coef_r[1]; op_b = v3_r; end
      3'd2:    begin op_a = coef_r[1]; op_b = s1_r; end
      3'd3:    begin op_a = coef_r[2]; op_b = v3_r; end
      3'd4:    begin op_a = coef_r[3]; op_b = x_r;  end
      3'd5:    begin op_a = coef_r[4]; op_b = v1_r; end
      3'd6:    begin op_a = coef_r[5]; op_b = v2_r; end
      default: begin op_a = '0;        op_b = '0;   end
    endcase
  end

  assign acc_sum = acc_r + rnd23(prod_r);
  assign s1_new  = 34'(v1_r) + 34'(v1_r) - 34'(s1_r);
  assign s2_new  = 34'(v2_r) + 34'(v2_r) - 34'(s2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= C_IDLE;
      step_r    <= '0;
      out_r.vld <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        s1_mem_r[i] <= '0;
        s2_mem_r[i] <= '0;
      end
    end else begin
      state_r   <= state_nxt;
      out_r.vld <= 1'b0;
      case (state_r)
        C_IDLE: begin
          step_r <= '0;
          x_r    <= link_in.x;
          ch_r   <= CH_W'(channel);
          if (link_in.vld && bypass_r) begin
            out_r.vld <= 1'b1;
            out_r.x   <= link_in.x;
          end
        end
        C_V3: begin
          s1_r <= s1_mem_r[ch_r];
          s2_r <= s2_mem_r[ch_r];
          v3_r <= sat32(ACC_W'(x_r) - ACC_W'(s2_mem_r[ch_r]));
        end
        C_RUN: begin
          step_r <= step_r + 3'd1;
          prod_r <= 64'(op_a) * 64'(op_b);
          case (step_r)
            3'd1: acc_r <= rnd23(prod_r);
            3'd2: begin
              v1_r  <= sat32(acc_sum);
              acc_r <= ACC_W'(s2_r);
            end
            3'd3: acc_r <= acc_sum;
            3'd4: begin
              v2_r  <= sat32(acc_sum);
              acc_r <= '0;
            end
            3'd5: acc_r <= acc_sum;
            3'd6: acc_r <= acc_sum;
            3'd7: begin
              out_r.vld      <= 1'b1;
              out_r.x        <= sat32(acc_sum);
              s1_mem_r[ch_r] <= sat32(ACC_W'(s1_new));
              s2_mem_r[ch_r] <= sat32(ACC_W'(s2_new));
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  assign link_out = out_r;

endmodule

>>> sv/svf_eq_band_cascade.sv
// Channel  Ports                          Handshake
// in       in_valid in_ready in_item      valid/ready
// out      out_valid out_ready out_item   valid/ready
// cfg      cfg_wr_en cfg_wr_data          write enable, no wait
//
// A filtered sample walks the band cells in order; an active band runs
// capture, state read, seven products on the cell's multiplier and a final
// sum; a bypassed band hands the sample straight to its output register.
// Unfiltered samples pass only the skid and output registers.
// Reset is synchronous; a finished item waits in a skid register and blocks
// input; once it moves on, a new item is accepted while the output stalls.
module svf_eq_band_cascade #(
  parameter int BANDS    = svfeq_pkg::BANDS_DEF,
  parameter int CHANNELS = svfeq_pkg::CHANNELS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  svfeq_pkg::in_item_t  in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output svfeq_pkg::out_item_t out_item,
  input  logic                 cfg_wr_en,
  input  logic [3:0]           cfg_wr_data
);
  import svfeq_pkg::*;

  logic [3:0]  nch_r;
  logic [4:0]  nch_eff;
  logic        busy_r;
  logic [2:0]  ch_r;
  link_t       start_r;
  link_t       links [BANDS+1];
  logic        fin_valid_r;
  out_item_t   fin_r;
  logic        out_valid_r;
  out_item_t   out_r;
  coef_wr_t    wr;
  logic        acc_in, filt, move;

  always_comb begin
    if (nch_r == 4'd0) begin
      nch_eff = 5'd1;
    end else if (32'(nch_r) > CHANNELS) begin
      nch_eff = 5'(CHANNELS);
    end else begin
      nch_eff = {1'b0, nch_r};
    end
  end

  assign in_ready = !busy_r && !fin_valid_r;
  assign acc_in   = in_valid && in_ready;
  assign filt     = {2'b00, in_item.channel} < nch_eff;
  assign move     = fin_valid_r && (!out_valid_r || out_ready);

  assign wr = '{en:    acc_in && (in_item.operation == OP_WRITE),
                band:  in_item.band,
                sel:   in_item.coef_select,
                value: in_item.coef_value};

  assign links[0] = start_r;

  for (genvar b = 0; b < BANDS; b++) begin : g_band
    svfeq_cell #(
      .BAND_IDX(b),
      .CHANNELS(CHANNELS)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .wr      (wr),
      .channel (ch_r),
      .link_in (links[b]),
      .link_out(links[b+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nch_r       <= 4'd2;
      busy_r      <= 1'b0;
      start_r.vld <= 1'b0;
      fin_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        nch_r <= cfg_wr_data;
      end
      start_r.vld <= 1'b0;
      if (acc_in && in_item.operation == OP_SAMPLE) begin
        ch_r <= in_item.channel;
        if (filt) begin
          busy_r      <= 1'b1;
          start_r.vld <= 1'b1;
          start_r.x   <= 32'(in_item.sample_in);
        end else begin
          fin_valid_r       <= 1'b1;
          fin_r.sample_out  <= in_item.sample_in;
          fin_r.out_channel <= in_item.channel;
        end
      end
      if (links[BANDS].vld) begin
        busy_r            <= 1'b0;
        fin_valid_r       <= 1'b1;
        fin_r.out_channel <= ch_r;
        if (links[BANDS].x > 32'sd8388607) begin
          fin_r.sample_out <= 24'sh7fffff;
        end else if (links[BANDS].x < -32'sd8388608) begin
          fin_r.sample_out <= 24'sh800000;
        end else begin
          fin_r.sample_out <= links[BANDS].x[23:0];
        end
      end
      if (move) begin
        fin_valid_r <= 1'b0;
        out_valid_r <= 1'b1;
        out_r       <= fin_r;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule
